[hw/rtl/gcb_pkg.sv]
package gcb_pkg;

	localparam logic [3:0] GC_OTHER       = 4'd0;
	localparam logic [3:0] GC_CR          = 4'd1;
	localparam logic [3:0] GC_LF          = 4'd2;
	localparam logic [3:0] GC_CONTROL     = 4'd3;
	localparam logic [3:0] GC_EXTEND      = 4'd4;
	localparam logic [3:0] GC_ZWJ         = 4'd5;
	localparam logic [3:0] GC_RI          = 4'd6;
	localparam logic [3:0] GC_PREPEND     = 4'd7;
	localparam logic [3:0] GC_SPACINGMARK = 4'd8;
	localparam logic [3:0] GC_L           = 4'd9;
	localparam logic [3:0] GC_V           = 4'd10;
	localparam logic [3:0] GC_T           = 4'd11;
	localparam logic [3:0] GC_LV          = 4'd12;
	localparam logic [3:0] GC_LVT         = 4'd13;
	localparam logic [3:0] GC_EXTPICT     = 4'd14;
	localparam logic [3:0] GC_UNUSED      = 4'd15;

	// emoji ZWJ chain tracker
	localparam logic [1:0] CHAIN_NONE  = 2'd0;
	localparam logic [1:0] CHAIN_PICT  = 2'd1;
	localparam logic [1:0] CHAIN_ARMED = 2'd2;

	typedef struct packed {
		logic [3:0] prev_class;
		logic [1:0] pict_chain;
		logic       ri_parity;
		logic       at_first;
	} gcb_state_t;

	localparam gcb_state_t GCB_STATE_RESET = '{
		prev_class: GC_OTHER,
		pict_chain: CHAIN_NONE,
		ri_parity:  1'b0,
		at_first:   1'b1
	};

	typedef struct packed {
		logic [3:0] break_class;
		logic       is_ext_pict;
		logic       wide_trail;
		logic       restart;
	} gcb_req_t;

endpackage

[hw/rtl/grapheme_cluster_boundary.sv]
// channel | signals                                              | direction
// in      | in_valid, in_stall, break_class, is_ext_pict,        | request in
//         | wide_trail, restart                                  |
// out     | out_valid, out_stall, is_start                       | result out
//
// One request per cycle sustained while the result is not stalled; each request
// produces exactly one result. A request sits in the input register until it
// advances, which registers its result into the result register.
// Cluster history advances when a request moves from the input register into
// the result register. A stalled result holds both stages; in_stall rises
// only while both stages are full. arst_n clears history (first char breaks).
module grapheme_cluster_boundary (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] break_class,
	input  logic       is_ext_pict,
	input  logic       wide_trail,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_start
);
	import gcb_pkg::*;

	gcb_req_t   req_s1;
	logic       valid_s1;
	gcb_state_t state_q;
	gcb_state_t state_nxt;
	logic       brk;
	logic       advance;
	logic       in_take;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	gcb_rules u_rules (
		.req (req_s1),
		.cur (state_q),
		.brk (brk),
		.nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
			state_q   <= GCB_STATE_RESET;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
				state_q   <= state_nxt;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= '{
				break_class: break_class,
				is_ext_pict: is_ext_pict,
				wide_trail:  wide_trail,
				restart:     restart
			};
		end
		if (advance) begin
			is_start <= brk;
		end
	end

endmodule

[hw/rtl/gcb_rules.sv]
module gcb_rules (
	input  gcb_pkg::gcb_req_t   req,
	input  gcb_pkg::gcb_state_t cur,
	output logic                brk,
	output gcb_pkg::gcb_state_t nxt
);
	import gcb_pkg::*;

	logic [3:0] cls;
	gcb_state_t base;
	logic       armed;
	logic       pair_brk;
	logic       p_ctl;
	logic       n_ctl;

	assign cls = (req.break_class == GC_UNUSED) ? GC_OTHER : req.break_class;

	// restart clears history before the character is judged
	assign base = req.restart ? GCB_STATE_RESET : cur;

	assign armed = (base.prev_class == GC_ZWJ) && (base.pict_chain == CHAIN_ARMED) &&
		(cls == GC_EXTPICT);
	assign p_ctl = (base.prev_class == GC_CONTROL) || (base.prev_class == GC_CR) ||
		(base.prev_class == GC_LF);
	assign n_ctl = (cls == GC_CONTROL) || (cls == GC_CR) || (cls == GC_LF);

	always_comb begin
		logic [3:0] p;
		p = base.prev_class;
		priority if (p == GC_CR && cls == GC_LF) begin
			pair_brk = 1'b0;
		end else if (p_ctl || n_ctl) begin
			pair_brk = 1'b1;
		end else if (p == GC_L && (cls == GC_L || cls == GC_V || cls == GC_LV ||
				cls == GC_LVT)) begin
			pair_brk = 1'b0;
		end else if ((p == GC_LV || p == GC_V) && (cls == GC_V || cls == GC_T)) begin
			pair_brk = 1'b0;
		end else if ((p == GC_LVT || p == GC_T) && cls == GC_T) begin
			pair_brk = 1'b0;
		end else if (cls == GC_EXTEND || cls == GC_ZWJ || cls == GC_SPACINGMARK) begin
			pair_brk = 1'b0;
		end else if (p == GC_PREPEND || (p == GC_ZWJ && armed)) begin
			pair_brk = 1'b0;
		end else if (p == GC_RI && cls == GC_RI && base.ri_parity) begin
			pair_brk = 1'b0;
		end else begin
			pair_brk = 1'b1;
		end
	end

	always_comb begin
		nxt = base;
		brk = 1'b0;
		if (!req.wide_trail) begin
			brk = base.at_first | pair_brk;
			priority if (cls == GC_EXTEND) begin
				nxt.pict_chain = (base.pict_chain == CHAIN_PICT) ? CHAIN_PICT : CHAIN_NONE;
			end else if (cls == GC_ZWJ) begin
				nxt.pict_chain = (base.pict_chain == CHAIN_PICT) ? CHAIN_ARMED : CHAIN_NONE;
			end else if (req.is_ext_pict) begin
				nxt.pict_chain = CHAIN_PICT;
			end else begin
				nxt.pict_chain = CHAIN_NONE;
			end
			nxt.ri_parity  = (cls == GC_RI) ? ~base.ri_parity : 1'b0;
			nxt.prev_class = cls;
			nxt.at_first   = 1'b0;
		end
	end

endmodule
